// ===== hw/rtl/mer_pkg.sv =====
`default_nettype none

package mer_pkg;

  localparam int COLOR_BITS = 4;

  localparam logic CMD_START   = 1'b0;
  localparam logic CMD_ADVANCE = 1'b1;

  typedef logic [3:0] mul_sel_t;
  typedef logic [3:0] use_op_t;

  localparam mul_sel_t MUL_AA     = 4'd0;
  localparam mul_sel_t MUL_BB     = 4'd1;
  localparam mul_sel_t MUL_A_INIT = 4'd2;
  localparam mul_sel_t MUL_A_TEST = 4'd3;
  localparam mul_sel_t MUL_B_TEST = 4'd4;
  localparam mul_sel_t MUL_B_R1   = 4'd5;
  localparam mul_sel_t MUL_A_R1   = 4'd6;
  localparam mul_sel_t MUL_XSQ    = 4'd7;
  localparam mul_sel_t MUL_B_SQ   = 4'd8;
  localparam mul_sel_t MUL_AB     = 4'd9;
  localparam mul_sel_t MUL_YSQ    = 4'd10;
  localparam mul_sel_t MUL_A_SQ   = 4'd11;
  localparam mul_sel_t MUL_B_R2   = 4'd12;
  localparam mul_sel_t MUL_A_R2   = 4'd13;

  localparam use_op_t USE_NONE           = 4'd0;
  localparam use_op_t USE_LOAD_A         = 4'd1;
  localparam use_op_t USE_LOAD_B         = 4'd2;
  localparam use_op_t USE_DEC_INIT       = 4'd3;
  localparam use_op_t USE_ACC_LOAD       = 4'd4;
  localparam use_op_t USE_ACC_LOAD4      = 4'd5;
  localparam use_op_t USE_ACC_ADD4_IFPOS = 4'd6;
  localparam use_op_t USE_R1_COMMIT      = 4'd7;
  localparam use_op_t USE_ACC_SUB4       = 4'd8;
  localparam use_op_t USE_DEC_ENTRY      = 4'd9;
  localparam use_op_t USE_ACC_LOAD4_IFNEG = 4'd10;
  localparam use_op_t USE_ACC_ADD4       = 4'd11;
  localparam use_op_t USE_R2_COMMIT      = 4'd12;

  typedef struct packed {
    logic     latch_start;
    mul_sel_t mul_sel;
    use_op_t  use_op;
    logic     emit;
    logic     emit_zero;
  } ctrl_cmd_t;

  typedef struct packed {
    logic drawing;
    logic region2;
    logic r1_go;
    logic out_free;
  } ctrl_status_t;

endpackage

`default_nettype wire

// ===== hw/rtl/mer_dp.sv =====
`default_nettype none

module mer_dp import mer_pkg::*; #(
  parameter int RADIUS_BITS = 8,
  parameter int COORD_BITS = 10
) (
  input  logic                         clk,
  input  logic                         rst,
  input  ctrl_cmd_t                    cmd,
  output ctrl_status_t                 status,
  input  logic [RADIUS_BITS-1:0]       semi_axis_a,
  input  logic [RADIUS_BITS-1:0]       semi_axis_b,
  input  logic [COORD_BITS-1:0]        centre_col,
  input  logic [COORD_BITS-1:0]        centre_row,
  input  logic [COLOR_BITS-1:0]        pen_color,
  input  logic                         pix_ready,
  output logic                         pix_valid,
  output logic                         plot_valid,
  output logic signed [COORD_BITS+1:0] pt0_col,
  output logic signed [COORD_BITS+1:0] pt0_row,
  output logic signed [COORD_BITS+1:0] pt1_col,
  output logic signed [COORD_BITS+1:0] pt1_row,
  output logic signed [COORD_BITS+1:0] pt2_col,
  output logic signed [COORD_BITS+1:0] pt2_row,
  output logic signed [COORD_BITS+1:0] pt3_col,
  output logic signed [COORD_BITS+1:0] pt3_row,
  output logic [COLOR_BITS-1:0]        out_color,
  output logic                         last_step
);

  localparam int XW  = RADIUS_BITS + 1;
  localparam int SQW = 2 * RADIUS_BITS;
  localparam int MW  = 2 * RADIUS_BITS + 5;
  localparam int DW  = 4 * RADIUS_BITS + 8;
  localparam int PW  = COORD_BITS + 2;

  localparam logic signed [MW-1:0] K1 = MW'(1);
  localparam logic signed [MW-1:0] K2 = MW'(2);
  localparam logic signed [MW-1:0] K3 = MW'(3);
  localparam logic [RADIUS_BITS-1:0] Y_STEP = RADIUS_BITS'(1);
  localparam logic [XW-1:0] X_STEP = XW'(1);

  logic [RADIUS_BITS-1:0] a_r;
  logic [RADIUS_BITS-1:0] b_r;
  logic [SQW-1:0]         a_sq;
  logic [SQW-1:0]         b_sq;
  logic [XW-1:0]          x;
  logic [RADIUS_BITS-1:0] y;
  logic signed [DW-1:0]   dec;
  logic signed [DW-1:0]   acc;
  logic signed [DW-1:0]   prod;
  logic [COORD_BITS-1:0]  cx;
  logic [COORD_BITS-1:0]  cy;
  logic [COLOR_BITS-1:0]  color;
  logic                   drawing;
  logic                   region2;

  logic signed [MW-1:0]   x_s;
  logic signed [MW-1:0]   y_s;
  logic signed [MW-1:0]   ain_s;
  logic signed [MW-1:0]   bin_s;
  logic signed [MW-1:0]   asq_s;
  logic signed [MW-1:0]   bsq_s;
  logic signed [MW-1:0]   sq_s;
  logic signed [MW-1:0]   op_l;
  logic signed [MW-1:0]   op_r;
  logic signed [2*MW-1:0] mul_full;
  logic signed [DW-1:0]   prod2;
  logic signed [DW-1:0]   prod4;
  logic signed [DW-1:0]   bsq4;
  logic                   dec_neg;

  logic [PW-1:0] cx_p;
  logic [PW-1:0] cy_p;
  logic [PW-1:0] x_p;
  logic [PW-1:0] y_p;

  assign x_s   = $signed(MW'(x));
  assign y_s   = $signed(MW'(y));
  assign ain_s = $signed(MW'(a_r));
  assign bin_s = $signed(MW'(b_r));
  assign asq_s = $signed(MW'(a_sq));
  assign bsq_s = $signed(MW'(b_sq));
  assign sq_s  = $signed(MW'(prod[SQW+3:0]));

  always_comb begin
    op_l = asq_s;
    op_r = K1;
    case (cmd.mul_sel)
      MUL_AA: begin
        op_l = ain_s;
        op_r = ain_s;
      end
      MUL_BB: begin
        op_l = bin_s;
        op_r = bin_s;
      end
      MUL_A_INIT: begin
        op_l = asq_s;
        op_r = K1 - (bin_s <<< 2);
      end
      MUL_A_TEST: begin
        op_l = asq_s;
        op_r = (y_s <<< 1) - K1;
      end
      MUL_B_TEST: begin
        op_l = bsq_s;
        op_r = x_s + K1;
      end
      MUL_B_R1: begin
        op_l = bsq_s;
        op_r = (x_s <<< 1) + K3;
      end
      MUL_A_R1: begin
        op_l = asq_s;
        op_r = K2 - (y_s <<< 1);
      end
      MUL_XSQ: begin
        op_l = (x_s <<< 1) + K1;
        op_r = (x_s <<< 1) + K1;
      end
      MUL_B_SQ: begin
        op_l = bsq_s;
        op_r = sq_s;
      end
      MUL_AB: begin
        op_l = asq_s;
        op_r = bsq_s;
      end
      MUL_YSQ: begin
        op_l = y_s - K1;
        op_r = y_s - K1;
      end
      MUL_A_SQ: begin
        op_l = asq_s;
        op_r = sq_s;
      end
      MUL_B_R2: begin
        op_l = bsq_s;
        op_r = (x_s <<< 1) + K2;
      end
      MUL_A_R2: begin
        op_l = asq_s;
        op_r = K3 - (y_s <<< 1);
      end
      default: begin
        op_l = asq_s;
        op_r = K1;
      end
    endcase
  end

  assign mul_full = op_l * op_r;
  assign prod2    = prod <<< 1;
  assign prod4    = prod <<< 2;
  assign bsq4     = $signed(DW'(b_sq)) <<< 2;
  assign dec_neg  = dec[DW-1];

  assign status.drawing  = drawing;
  assign status.region2  = region2;
  assign status.r1_go    = (acc >= prod2);
  assign status.out_free = !pix_valid || pix_ready;

  always_ff @(posedge clk) begin
    prod <= $signed(mul_full[DW-1:0]);
    if (cmd.latch_start) begin
      a_r   <= semi_axis_a;
      b_r   <= semi_axis_b;
      cx    <= centre_col;
      cy    <= centre_row;
      color <= pen_color;
      x     <= '0;
      y     <= semi_axis_b;
    end
    case (cmd.use_op)
      USE_LOAD_A: begin
        a_sq <= prod[SQW-1:0];
      end
      USE_LOAD_B: begin
        b_sq <= prod[SQW-1:0];
      end
      USE_DEC_INIT: begin
        dec <= bsq4 + prod;
      end
      USE_ACC_LOAD: begin
        acc <= prod;
      end
      USE_ACC_LOAD4: begin
        acc <= prod4;
      end
      USE_ACC_ADD4_IFPOS: begin
        if (!dec_neg) begin
          acc <= acc + prod4;
        end
      end
      USE_R1_COMMIT: begin
        dec <= dec + acc;
        x   <= x + X_STEP;
        if (!dec_neg) begin
          y <= y - Y_STEP;
        end
      end
      USE_ACC_SUB4: begin
        acc <= acc - prod4;
      end
      USE_DEC_ENTRY: begin
        dec <= acc + prod4;
      end
      USE_ACC_LOAD4_IFNEG: begin
        acc <= dec_neg ? prod4 : '0;
      end
      USE_ACC_ADD4: begin
        acc <= acc + prod4;
      end
      USE_R2_COMMIT: begin
        dec <= dec + acc;
        y   <= y - Y_STEP;
        if (dec_neg) begin
          x <= x + X_STEP;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      drawing   <= 1'b0;
      region2   <= 1'b0;
      pix_valid <= 1'b0;
    end else begin
      if (cmd.latch_start) begin
        region2 <= 1'b0;
      end else if (cmd.use_op == USE_DEC_ENTRY) begin
        region2 <= 1'b1;
      end
      if (cmd.emit && !cmd.emit_zero) begin
        drawing <= (y != '0);
      end
      if (cmd.emit) begin
        pix_valid <= 1'b1;
      end else if (pix_ready) begin
        pix_valid <= 1'b0;
      end
    end
  end

  assign cx_p = PW'(cx);
  assign cy_p = PW'(cy);
  assign x_p  = PW'(x);
  assign y_p  = PW'(y);

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      if (cmd.emit_zero) begin
        plot_valid <= 1'b0;
        pt0_col    <= '0;
        pt0_row    <= '0;
        pt1_col    <= '0;
        pt1_row    <= '0;
        pt2_col    <= '0;
        pt2_row    <= '0;
        pt3_col    <= '0;
        pt3_row    <= '0;
        out_color  <= '0;
        last_step  <= 1'b0;
      end else begin
        plot_valid <= 1'b1;
        pt0_col    <= $signed(cx_p + x_p);
        pt0_row    <= $signed(cy_p + y_p);
        pt1_col    <= $signed(cx_p + x_p);
        pt1_row    <= $signed(cy_p - y_p);
        pt2_col    <= $signed(cx_p - x_p);
        pt2_row    <= $signed(cy_p + y_p);
        pt3_col    <= $signed(cx_p - x_p);
        pt3_row    <= $signed(cy_p - y_p);
        out_color  <= color;
        last_step  <= (y == '0);
      end
    end
  end

  a_commit_y_nonzero: assert property (@(posedge clk) disable iff (rst)
    (cmd.use_op == USE_R1_COMMIT || cmd.use_op == USE_R2_COMMIT) |-> (y != '0))
    else $error("Step committed with the vertical offset already at zero.");

  a_emit_sets_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |=> pix_valid)
    else $error("Result register not marked full after an emit.");

  a_entry_once: assert property (@(posedge clk) disable iff (rst)
    (cmd.use_op == USE_DEC_ENTRY) |-> !region2)
    else $error("Region two entry taken while already in region two.");

endmodule

`default_nettype wire

// ===== hw/rtl/mer_ctrl.sv =====
`default_nettype none

module mer_ctrl import mer_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         cmd_valid,
  output logic         cmd_ready,
  input  logic         command,
  input  ctrl_status_t status,
  output ctrl_cmd_t    cmd
);

  localparam logic [4:0] ST_IDLE     = 5'd0;
  localparam logic [4:0] ST_S1       = 5'd1;
  localparam logic [4:0] ST_S2       = 5'd2;
  localparam logic [4:0] ST_S3       = 5'd3;
  localparam logic [4:0] ST_S4       = 5'd4;
  localparam logic [4:0] ST_T1       = 5'd5;
  localparam logic [4:0] ST_T2       = 5'd6;
  localparam logic [4:0] ST_T3       = 5'd7;
  localparam logic [4:0] ST_R1A      = 5'd8;
  localparam logic [4:0] ST_R1B      = 5'd9;
  localparam logic [4:0] ST_R1C      = 5'd10;
  localparam logic [4:0] ST_E2       = 5'd11;
  localparam logic [4:0] ST_E3       = 5'd12;
  localparam logic [4:0] ST_E4       = 5'd13;
  localparam logic [4:0] ST_E5       = 5'd14;
  localparam logic [4:0] ST_E6       = 5'd15;
  localparam logic [4:0] ST_F1       = 5'd16;
  localparam logic [4:0] ST_F2       = 5'd17;
  localparam logic [4:0] ST_F3       = 5'd18;
  localparam logic [4:0] ST_F4       = 5'd19;
  localparam logic [4:0] ST_FIN      = 5'd20;
  localparam logic [4:0] ST_FIN_ZERO = 5'd21;

  logic [4:0] state;
  logic [4:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next      = state;
    cmd_ready       = 1'b0;
    cmd.latch_start = 1'b0;
    cmd.mul_sel     = MUL_AA;
    cmd.use_op      = USE_NONE;
    cmd.emit        = 1'b0;
    cmd.emit_zero   = 1'b0;
    case (state)
      ST_IDLE: begin
        cmd_ready = 1'b1;
        if (cmd_valid) begin
          if (command == CMD_START) begin
            cmd.latch_start = 1'b1;
            state_next      = ST_S1;
          end else if (status.drawing) begin
            state_next = status.region2 ? ST_F1 : ST_T1;
          end else begin
            state_next = ST_FIN_ZERO;
          end
        end
      end
      ST_S1: begin
        cmd.mul_sel = MUL_AA;
        state_next  = ST_S2;
      end
      ST_S2: begin
        cmd.use_op  = USE_LOAD_A;
        cmd.mul_sel = MUL_BB;
        state_next  = ST_S3;
      end
      ST_S3: begin
        cmd.use_op  = USE_LOAD_B;
        cmd.mul_sel = MUL_A_INIT;
        state_next  = ST_S4;
      end
      ST_S4: begin
        cmd.use_op = USE_DEC_INIT;
        state_next = ST_FIN;
      end
      ST_T1: begin
        cmd.mul_sel = MUL_A_TEST;
        state_next  = ST_T2;
      end
      ST_T2: begin
        cmd.use_op  = USE_ACC_LOAD;
        cmd.mul_sel = MUL_B_TEST;
        state_next  = ST_T3;
      end
      ST_T3: begin
        if (status.r1_go) begin
          cmd.mul_sel = MUL_B_R1;
          state_next  = ST_R1A;
        end else begin
          cmd.mul_sel = MUL_XSQ;
          state_next  = ST_E2;
        end
      end
      ST_R1A: begin
        cmd.use_op  = USE_ACC_LOAD4;
        cmd.mul_sel = MUL_A_R1;
        state_next  = ST_R1B;
      end
      ST_R1B: begin
        cmd.use_op = USE_ACC_ADD4_IFPOS;
        state_next = ST_R1C;
      end
      ST_R1C: begin
        cmd.use_op = USE_R1_COMMIT;
        state_next = ST_FIN;
      end
      ST_E2: begin
        cmd.mul_sel = MUL_B_SQ;
        state_next  = ST_E3;
      end
      ST_E3: begin
        cmd.use_op  = USE_ACC_LOAD;
        cmd.mul_sel = MUL_AB;
        state_next  = ST_E4;
      end
      ST_E4: begin
        cmd.use_op  = USE_ACC_SUB4;
        cmd.mul_sel = MUL_YSQ;
        state_next  = ST_E5;
      end
      ST_E5: begin
        cmd.mul_sel = MUL_A_SQ;
        state_next  = ST_E6;
      end
      ST_E6: begin
        cmd.use_op  = USE_DEC_ENTRY;
        cmd.mul_sel = MUL_B_R2;
        state_next  = ST_F2;
      end
      ST_F1: begin
        cmd.mul_sel = MUL_B_R2;
        state_next  = ST_F2;
      end
      ST_F2: begin
        cmd.use_op  = USE_ACC_LOAD4_IFNEG;
        cmd.mul_sel = MUL_A_R2;
        state_next  = ST_F3;
      end
      ST_F3: begin
        cmd.use_op = USE_ACC_ADD4;
        state_next = ST_F4;
      end
      ST_F4: begin
        cmd.use_op = USE_R2_COMMIT;
        state_next = ST_FIN;
      end
      ST_FIN: begin
        if (status.out_free) begin
          cmd.emit   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_FIN_ZERO: begin
        if (status.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_zero = 1'b1;
          state_next    = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  a_emit_only_when_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> status.out_free)
    else $error("Result emitted while the output register is still full.");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    (cmd_valid && cmd_ready) |=> (state != ST_IDLE))
    else $error("Accepted beat did not start any work.");

  a_test_in_region_one: assert property (@(posedge clk) disable iff (rst)
    (state == ST_T3) |-> !status.region2)
    else $error("Region one test evaluated while in region two.");

endmodule

`default_nettype wire

// ===== hw/rtl/midpoint_ellipse_rasterizer.sv =====
// Channel  Handshake              Payload
// cmd      cmd_valid / cmd_ready  command, semi_axis_a, semi_axis_b, centre_col, centre_row,
//                                 pen_color
// pix      pix_valid / pix_ready  plot_valid, pt0..pt3 col/row, out_color, last_step
//
// One shared multiplier, registered at its output, does every product, so a beat passes
// through idle and then one sequencer state per step; start, region one step, the step that
// enters region two, region two step and advance while idle each have their own run of states.
// A new command beat is taken while the previous result still waits in the output register.
// The sequencer holds in its final step while the output register is full and not taken.
// Synchronous reset returns the sequencer to idle and empties the output register.
`default_nettype none

module midpoint_ellipse_rasterizer import mer_pkg::*; #(
  parameter int RADIUS_BITS = 8,
  parameter int COORD_BITS = 10
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cmd_valid,
  output logic                         cmd_ready,
  input  logic                         command,
  input  logic [RADIUS_BITS-1:0]       semi_axis_a,
  input  logic [RADIUS_BITS-1:0]       semi_axis_b,
  input  logic [COORD_BITS-1:0]        centre_col,
  input  logic [COORD_BITS-1:0]        centre_row,
  input  logic [COLOR_BITS-1:0]        pen_color,
  output logic                         pix_valid,
  input  logic                         pix_ready,
  output logic                         plot_valid,
  output logic signed [COORD_BITS+1:0] pt0_col,
  output logic signed [COORD_BITS+1:0] pt0_row,
  output logic signed [COORD_BITS+1:0] pt1_col,
  output logic signed [COORD_BITS+1:0] pt1_row,
  output logic signed [COORD_BITS+1:0] pt2_col,
  output logic signed [COORD_BITS+1:0] pt2_row,
  output logic signed [COORD_BITS+1:0] pt3_col,
  output logic signed [COORD_BITS+1:0] pt3_row,
  output logic [COLOR_BITS-1:0]        out_color,
  output logic                         last_step
);

  ctrl_cmd_t    cmd;
  ctrl_status_t status;

  mer_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .command   (command),
    .status    (status),
    .cmd       (cmd)
  );

  mer_dp #(
    .RADIUS_BITS (RADIUS_BITS),
    .COORD_BITS  (COORD_BITS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .semi_axis_a (semi_axis_a),
    .semi_axis_b (semi_axis_b),
    .centre_col  (centre_col),
    .centre_row  (centre_row),
    .pen_color   (pen_color),
    .pix_ready   (pix_ready),
    .pix_valid   (pix_valid),
    .plot_valid  (plot_valid),
    .pt0_col     (pt0_col),
    .pt0_row     (pt0_row),
    .pt1_col     (pt1_col),
    .pt1_row     (pt1_row),
    .pt2_col     (pt2_col),
    .pt2_row     (pt2_row),
    .pt3_col     (pt3_col),
    .pt3_row     (pt3_row),
    .out_color   (out_color),
    .last_step   (last_step)
  );

endmodule

`default_nettype wire

// ===== tb/midpoint_ellipse_rasterizer_test.sv =====
`timescale 1ns / 100ps

module midpoint_ellipse_rasterizer_test;
  import mer_pkg::*;

  localparam int TOTAL_BEATS = 850;
  localparam int CALM_FROM = 780;
  localparam int HOLD_AT = 300;
  localparam int HOLD_CYCLES = 250;
  localparam int DRAIN_AT = 520;
  localparam int MAX_PRINTED = 100;

  typedef struct packed {
    logic             plot;
    logic [0:7][11:0] pt;
    logic [3:0]       color;
    logic             last;
  } pix_beat_t;

  typedef struct packed {
    logic       op;
    logic [7:0] a;
    logic [7:0] b;
    logic [9:0] cx;
    logic [9:0] cy;
    logic [3:0] color;
    logic       typed;
    pix_beat_t  want;
  } stim_row_t;

  localparam pix_beat_t IDLE_PIX = '0;

  logic clk = 1'b0;
  logic rst;
  logic cmd_valid;
  logic cmd_ready;
  logic command;
  logic [7:0] semi_axis_a;
  logic [7:0] semi_axis_b;
  logic [9:0] centre_col;
  logic [9:0] centre_row;
  logic [COLOR_BITS-1:0] pen_color;
  logic pix_valid;
  logic pix_ready;
  logic plot_valid;
  logic signed [11:0] pt0_col;
  logic signed [11:0] pt0_row;
  logic signed [11:0] pt1_col;
  logic signed [11:0] pt1_row;
  logic signed [11:0] pt2_col;
  logic signed [11:0] pt2_row;
  logic signed [11:0] pt3_col;
  logic signed [11:0] pt3_row;
  logic [COLOR_BITS-1:0] out_color;
  logic last_step;

  midpoint_ellipse_rasterizer DUT (
    .clk(clk),
    .rst(rst),
    .cmd_valid(cmd_valid),
    .cmd_ready(cmd_ready),
    .command(command),
    .semi_axis_a(semi_axis_a),
    .semi_axis_b(semi_axis_b),
    .centre_col(centre_col),
    .centre_row(centre_row),
    .pen_color(pen_color),
    .pix_valid(pix_valid),
    .pix_ready(pix_ready),
    .plot_valid(plot_valid),
    .pt0_col(pt0_col),
    .pt0_row(pt0_row),
    .pt1_col(pt1_col),
    .pt1_row(pt1_row),
    .pt2_col(pt2_col),
    .pt2_row(pt2_row),
    .pt3_col(pt3_col),
    .pt3_row(pt3_row),
    .out_color(out_color),
    .last_step(last_step)
  );

  always #5 clk = ~clk;

  // Predicted walk state, with decision values held at four times the textbook scale.
  longint walk_x;
  longint walk_y;
  longint walk_dec;
  longint walk_asq;
  longint walk_bsq;
  bit walk_region2;
  bit walk_drawing;
  logic [9:0] org_col;
  logic [9:0] org_row;
  logic [3:0] ink;

  pix_beat_t pending_pixels [$];
  int errors;
  int beats_sent;
  int send_gap_pct;
  bit calm;
  bit hold_request;

  stim_row_t plan [21] = '{
    '{CMD_ADVANCE, 8'd0, 8'd0, 10'd0, 10'd0, 4'd0, 1'b1, IDLE_PIX},
    '{CMD_START, 8'd0, 8'd0, 10'd1023, 10'd0, 4'd15, 1'b1,
      '{1'b1, {12'd1023, 12'd0, 12'd1023, 12'd0, 12'd1023, 12'd0, 12'd1023, 12'd0},
        4'd15, 1'b1}},
    '{CMD_ADVANCE, 8'hFF, 8'hFF, 10'h3FF, 10'h3FF, 4'hF, 1'b1, IDLE_PIX},
    '{CMD_START, 8'd255, 8'd255, 10'd1023, 10'd1023, 4'd0, 1'b1,
      '{1'b1, {12'd1023, 12'd1278, 12'd1023, 12'd768, 12'd1023, 12'd1278, 12'd1023,
        12'd768}, 4'd0, 1'b0}},
    '{CMD_ADVANCE, 8'd0, 8'd0, 10'd0, 10'd0, 4'd0, 1'b0, IDLE_PIX},
    '{CMD_ADVANCE, 8'd0, 8'd0, 10'd0, 10'd0, 4'd0, 1'b0, IDLE_PIX},
    '{CMD_ADVANCE, 8'd0, 8'd0, 10'd0, 10'd0, 4'd0, 1'b0, IDLE_PIX},
    '{CMD_START, 8'd1, 8'd1, 10'd0, 10'd0, 4'd10, 1'b1,
      '{1'b1, {12'd0, 12'd1, 12'd0, 12'hFFF, 12'd0, 12'd1, 12'd0, 12'hFFF}, 4'd10, 1'b0}},
    '{CMD_ADVANCE, 8'd0, 8'd0, 10'd0, 10'd0, 4'd0, 1'b0, IDLE_PIX},
    '{CMD_ADVANCE, 8'd0, 8'd0, 10'd0, 10'd0, 4'd0, 1'b0, IDLE_PIX},
    '{CMD_START, 8'd0, 8'd3, 10'd5, 10'd5, 4'd3, 1'b1,
      '{1'b1, {12'd5, 12'd8, 12'd5, 12'd2, 12'd5, 12'd8, 12'd5, 12'd2}, 4'd3, 1'b0}},
    '{CMD_ADVANCE, 8'd0, 8'd0, 10'd0, 10'd0, 4'd0, 1'b0, IDLE_PIX},
    '{CMD_ADVANCE, 8'd0, 8'd0, 10'd0, 10'd0, 4'd0, 1'b0, IDLE_PIX},
    '{CMD_ADVANCE, 8'd0, 8'd0, 10'd0, 10'd0, 4'd0, 1'b0, IDLE_PIX},
    '{CMD_ADVANCE, 8'd0, 8'd0, 10'd0, 10'd0, 4'd0, 1'b1, IDLE_PIX},
    '{CMD_START, 8'd4, 8'd1, 10'd0, 10'd1023, 4'd5, 1'b1,
      '{1'b1, {12'd0, 12'd1024, 12'd0, 12'd1022, 12'd0, 12'd1024, 12'd0, 12'd1022},
        4'd5, 1'b0}},
    '{CMD_ADVANCE, 8'd0, 8'd0, 10'd0, 10'd0, 4'd0, 1'b0, IDLE_PIX},
    '{CMD_ADVANCE, 8'd0, 8'd0, 10'd0, 10'd0, 4'd0, 1'b0, IDLE_PIX},
    '{CMD_ADVANCE, 8'd0, 8'd0, 10'd0, 10'd0, 4'd0, 1'b0, IDLE_PIX},
    '{CMD_ADVANCE, 8'd0, 8'd0, 10'd0, 10'd0, 4'd0, 1'b0, IDLE_PIX},
    '{CMD_START, 8'd255, 8'd255, 10'd0, 10'd0, 4'd15, 1'b1,
      '{1'b1, {12'd0, 12'd255, 12'd0, 12'hF01, 12'd0, 12'd255, 12'd0, 12'hF01},
        4'd15, 1'b0}}
  };

  function automatic pix_beat_t mirrored_pixels(input bit last);
    pix_beat_t r;
    r.plot = 1'b1;
    r.pt[0] = 12'(longint'(org_col) + walk_x);
    r.pt[1] = 12'(longint'(org_row) + walk_y);
    r.pt[2] = 12'(longint'(org_col) + walk_x);
    r.pt[3] = 12'(longint'(org_row) - walk_y);
    r.pt[4] = 12'(longint'(org_col) - walk_x);
    r.pt[5] = 12'(longint'(org_row) + walk_y);
    r.pt[6] = 12'(longint'(org_col) - walk_x);
    r.pt[7] = 12'(longint'(org_row) - walk_y);
    r.color = ink;
    r.last = last;
    return r;
  endfunction

  function automatic pix_beat_t next_ellipse_pixels(input logic op, input logic [7:0] a,
                                                    input logic [7:0] b,
                                                    input logic [9:0] cx,
                                                    input logic [9:0] cy,
                                                    input logic [3:0] color);
    longint x;
    longint y;
    longint aa;
    longint bb;
    if (op == CMD_START) begin
      walk_asq = longint'(a) * longint'(a);
      walk_bsq = longint'(b) * longint'(b);
      org_col = cx;
      org_row = cy;
      ink = color;
      walk_x = 0;
      walk_y = longint'(b);
      walk_dec = 4 * walk_bsq + walk_asq * (1 - 4 * longint'(b));
      walk_region2 = 1'b0;
      walk_drawing = (b != 0);
      return mirrored_pixels(b == 0);
    end
    if (!walk_drawing) begin
      return IDLE_PIX;
    end
    aa = walk_asq;
    bb = walk_bsq;
    x = walk_x;
    y = walk_y;
    if (!walk_region2) begin
      if (aa * (2 * y - 1) >= 2 * bb * (x + 1)) begin
        if (walk_dec < 0) begin
          walk_dec += 4 * bb * (2 * x + 3);
        end else begin
          walk_dec += 4 * bb * (2 * x + 3) + 4 * aa * (2 - 2 * y);
          y--;
        end
        x++;
      end else begin
        walk_region2 = 1'b1;
        walk_dec = bb * (2 * x + 1) * (2 * x + 1) + 4 * aa * (y - 1) * (y - 1) - 4 * aa * bb;
      end
    end
    if (walk_region2) begin
      if (walk_dec < 0) begin
        walk_dec += 4 * bb * (2 * x + 2) + 4 * aa * (3 - 2 * y);
        x++;
      end else begin
        walk_dec += 4 * aa * (3 - 2 * y);
      end
      y--;
    end
    walk_x = x & 511;
    walk_y = (y < 0) ? 0 : y;
    if (walk_y == 0) walk_drawing = 1'b0;
    return mirrored_pixels(walk_y == 0);
  endfunction

  task automatic report_mismatch(input string what);
    errors++;
    if (errors <= MAX_PRINTED) $display("mismatch at %0t: %s", $time, what);
  endtask

  function automatic logic [7:0] pick_axis();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 80) return 8'($urandom_range(0, 15));
    if (roll < 97) return 8'($urandom_range(16, 63));
    return 8'($urandom_range(64, 255));
  endfunction

  task automatic send_command(input logic op, input logic [7:0] a, input logic [7:0] b,
                              input logic [9:0] cx, input logic [9:0] cy,
                              input logic [3:0] color, input bit typed,
                              input pix_beat_t typed_want);
    int gap;
    pix_beat_t want;
    gap = 0;
    if (!calm && $urandom_range(0, 99) < send_gap_pct) gap = $urandom_range(1, 5);
    @(negedge clk);
    if (gap > 0) begin
      cmd_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    cmd_valid <= 1'b1;
    command <= op;
    semi_axis_a <= a;
    semi_axis_b <= b;
    centre_col <= cx;
    centre_row <= cy;
    pen_color <= color;
    do @(posedge clk); while (!cmd_ready);
    want = next_ellipse_pixels(op, a, b, cx, cy, color);
    if (typed) want = typed_want;
    pending_pixels.push_back(want);
    beats_sent++;
  endtask

  always @(posedge clk) begin : pixel_check
    pix_beat_t got;
    pix_beat_t want;
    if (!rst && pix_valid && pix_ready) begin
      got.plot = plot_valid;
      got.pt = {pt0_col, pt0_row, pt1_col, pt1_row, pt2_col, pt2_row, pt3_col, pt3_row};
      got.color = out_color;
      got.last = last_step;
      if (pending_pixels.size() == 0) begin
        report_mismatch("pixel beat arrived with nothing pending");
      end else begin
        want = pending_pixels.pop_front();
        if (got.plot !== want.plot)
          report_mismatch($sformatf("plot_valid %0b, wanted %0b", got.plot, want.plot));
        for (int i = 0; i < 8; i++) begin
          if (got.pt[i] !== want.pt[i])
            report_mismatch($sformatf("pt%0d_%s %0d, wanted %0d", i / 2,
                                      (i % 2) ? "row" : "col", $signed(got.pt[i]),
                                      $signed(want.pt[i])));
        end
        if (got.color !== want.color)
          report_mismatch($sformatf("out_color %0d, wanted %0d", got.color, want.color));
        if (got.last !== want.last)
          report_mismatch($sformatf("last_step %0b, wanted %0b", got.last, want.last));
      end
    end
  end

  initial begin : pixel_sink
    int stall_left;
    int hold_left;
    int stall_pct;
    int cycle;
    stall_left = 0;
    hold_left = 0;
    stall_pct = 0;
    cycle = 0;
    pix_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (cycle % 64 == 0) stall_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 35);
      cycle++;
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        pix_ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        pix_ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 99) < stall_pct) begin
        stall_left = $urandom_range(0, 4);
        pix_ready <= 1'b0;
      end else begin
        pix_ready <= 1'b1;
      end
    end
  end

  initial begin : command_source
    int roll;
    errors = 0;
    beats_sent = 0;
    send_gap_pct = 0;
    calm = 1'b0;
    hold_request = 1'b0;
    rst = 1'b1;
    cmd_valid = 1'b0;
    command = CMD_START;
    semi_axis_a = '0;
    semi_axis_b = '0;
    centre_col = '0;
    centre_row = '0;
    pen_color = '0;
    walk_x = 0;
    walk_y = 0;
    walk_dec = 0;
    walk_asq = 0;
    walk_bsq = 0;
    walk_region2 = 1'b0;
    walk_drawing = 1'b0;
    org_col = '0;
    org_row = '0;
    ink = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      send_command(plan[i].op, plan[i].a, plan[i].b, plan[i].cx, plan[i].cy, plan[i].color,
                   plan[i].typed, plan[i].want);
    end

    while (beats_sent < TOTAL_BEATS) begin
      if (beats_sent % 32 == 0) send_gap_pct = ($urandom_range(0, 2) == 0) ? 0 : 25;
      if (beats_sent == HOLD_AT) hold_request = 1'b1;
      if (beats_sent == DRAIN_AT) begin
        @(negedge clk);
        cmd_valid <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge clk);
      end
      if (beats_sent >= CALM_FROM) calm = 1'b1;
      roll = $urandom_range(0, 99);
      if (walk_drawing ? (roll < 3) : (roll >= 8)) begin
        send_command(CMD_START, pick_axis(), pick_axis(), 10'($urandom), 10'($urandom),
                     4'($urandom), 1'b0, IDLE_PIX);
      end else begin
        send_command(CMD_ADVANCE, 8'($urandom), 8'($urandom), 10'($urandom), 10'($urandom),
                     4'($urandom), 1'b0, IDLE_PIX);
      end
    end
    @(negedge clk);
    cmd_valid <= 1'b0;

    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    if (errors == 0) begin
      $display("midpoint_ellipse_rasterizer regression: pass");
    end else begin
      $display("midpoint_ellipse_rasterizer regression: fail");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("midpoint_ellipse_rasterizer regression: fail");
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/mer_pkg.sv
hw/rtl/mer_dp.sv
hw/rtl/mer_ctrl.sv
hw/rtl/midpoint_ellipse_rasterizer.sv
tb/midpoint_ellipse_rasterizer_test.sv
